### rtl/psg_erw_pkg.sv
// Shared types, register map constants and init sequence decode for the
// tone chip register writer. No dependencies.
`timescale 1ns / 1ps

package psg_erw_pkg;

  // Default shadow depth; the top level hands the real value down.
  localparam int SHADOW_DEPTH_DEF = 64;

  // Operation codes.
  localparam logic [3:0] OP_INIT      = 4'd0;
  localparam logic [3:0] OP_KEY_ON    = 4'd1;
  localparam logic [3:0] OP_KEY_OFF   = 4'd2;
  localparam logic [3:0] OP_VOLUME    = 4'd3;
  localparam logic [3:0] OP_VOICE     = 4'd4;
  localparam logic [3:0] OP_ENV_SHAPE = 4'd5;
  localparam logic [3:0] OP_ENV_LO    = 4'd6;
  localparam logic [3:0] OP_ENV_HI    = 4'd7;
  localparam logic [3:0] OP_PAN       = 4'd8;
  localparam logic [3:0] OP_REG_READ  = 4'd9;
  localparam logic [3:0] OP_REG_WRITE = 4'd10;

  // Chip register map, relative to one set.
  localparam logic [5:0] SET2_BASE  = 6'h20;
  localparam logic [7:0] NUM_REGS   = 8'h0E;
  localparam logic [5:0] REG_NOISE  = 6'h06;
  localparam logic [5:0] REG_ENABLE = 6'h07;
  localparam logic [5:0] REG_VOL    = 6'h08;
  localparam logic [5:0] REG_ENV_LO = 6'h0B;
  localparam logic [5:0] REG_ENV_HI = 6'h0C;
  localparam logic [5:0] REG_SHAPE  = 6'h0D;
  localparam logic [5:0] REG_PAN    = 6'h10;

  localparam logic [7:0] PAN_CENTRE = 8'h08;
  localparam logic [7:0] MIX_INIT   = 8'h38;
  localparam int         NUM_CHANS  = 6;

  // Length of the init clearing sequence.
  localparam int         INIT_WRITES = 34;
  localparam logic [5:0] INIT_LAST   = 6'(INIT_WRITES - 1);
  localparam logic [5:0] INIT_SET_START = 6'd24;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;   // latch a new input transaction
    logic       emit;   // produce one result and commit its state update
    logic [5:0] step;   // index of the result within the current item
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic last;         // the current step is the final result of the item
  } dp_sts_t;

  typedef struct packed {
    logic [5:0] addr;
    logic [7:0] data;
  } init_wr_t;

  // Voice position within its set.
  function automatic logic [1:0] ch_sub(input logic [2:0] ch);
    logic [1:0] sub;
    case (ch)
      3'd1, 3'd4: sub = 2'd1;
      3'd2, 3'd5: sub = 2'd2;
      default:    sub = 2'd0;
    endcase
    return sub;
  endfunction

  // Register base of the set that a channel belongs to.
  function automatic logic [5:0] ch_base(input logic [2:0] ch);
    return (ch >= 3'd3) ? SET2_BASE : 6'h00;
  endfunction

  // A raw register number is one of the chip's registers.
  function automatic logic reg_ok(input logic [7:0] r);
    return (r < NUM_REGS) ||
           (r >= 8'(SET2_BASE) && r < (8'(SET2_BASE) + NUM_REGS));
  endfunction

  // Address and data of one write of the init sequence. The first 24 steps
  // write four registers per channel, centring its pan; the last ten clear each
  // set's shared registers and end with the mixer at its init value.
  function automatic init_wr_t init_entry(input logic [5:0] step);
    init_wr_t   w;
    logic [2:0] c;
    logic [1:0] sub;
    logic [5:0] t;
    logic [5:0] j;
    logic [5:0] base;
    c = step[4:2];
    sub = ch_sub(c);
    t = step - INIT_SET_START;
    w.data = 8'h00;
    if (step < INIT_SET_START) begin
      base = ch_base(c);
      case (step[1:0])
        2'd0:    w.addr = base | {3'b000, sub, 1'b0};
        2'd1:    w.addr = base | {3'b000, sub, 1'b1};
        2'd2:    w.addr = base | (REG_VOL + {4'b0000, sub});
        default: begin
          w.addr = base | (REG_PAN + {4'b0000, sub});
          w.data = PAN_CENTRE;
        end
      endcase
    end else begin
      if (t >= 6'd5) begin
        base = SET2_BASE;
        j = t - 6'd5;
      end else begin
        base = 6'h00;
        j = t;
      end
      case (j)
        6'd0:    w.addr = base | REG_NOISE;
        6'd1:    w.addr = base | REG_ENV_LO;
        6'd2:    w.addr = base | REG_ENV_HI;
        6'd3:    w.addr = base | REG_SHAPE;
        default: begin
          w.addr = base | REG_ENABLE;
          w.data = MIX_INIT;
        end
      endcase
    end
    return w;
  endfunction

endpackage

### rtl/psg_erw_if.sv
// Valid/ready channel interfaces for music event input and register
// write results. No dependencies.
`timescale 1ns / 1ps

interface psg_erw_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  logic [2:0] channel;
  logic [7:0] data_value;
  logic [7:0] reg_addr;

  modport source (output valid, operation, channel, data_value, reg_addr,
                  input ready);
  modport sink   (input valid, operation, channel, data_value, reg_addr,
                  output ready);
endinterface

interface psg_erw_out_if;
  logic       valid;
  logic       ready;
  logic       write_valid;
  logic [5:0] write_addr;
  logic [7:0] write_data;
  logic [7:0] read_data;
  logic       status;
  logic       last;

  modport source (output valid, write_valid, write_addr, write_data, read_data,
                  status, last, input ready);
  modport sink   (input valid, write_valid, write_addr, write_data, read_data,
                  status, last, output ready);
endinterface

### rtl/psg_erw_ctrl.sv
// Controller for the register writer: takes one input transaction at a time
// and steps through its results. Depends on psg_erw_pkg.
`timescale 1ns / 1ps

module psg_erw_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  psg_erw_pkg::dp_sts_t   sts,
  output psg_erw_pkg::ctrl_cmd_t cmd
);
  import psg_erw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] step_r, step_nxt;

  // Handshake and commands.
  assign in_ready = (state_r == ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.emit = (state_r == ST_EMIT) && sts.out_free;
  assign cmd.step = step_r;

  // Next state and step count.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_EMIT;
          step_nxt  = 6'd0;
        end
      end
      ST_EMIT: begin
        if (cmd.emit) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
            step_nxt  = 6'd0;
          end else begin
            step_nxt = step_r + 6'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 6'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (step_r == 6'd0))
    else $error("step count not cleared while idle");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= INIT_LAST)
    else $error("step count ran past the longest sequence");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last) |=> (state_r == ST_IDLE))
    else $error("controller did not finish after the last result");
`endif

endmodule

### rtl/psg_erw_dp.sv
// Datapath for the register writer: item latch, result decode, channel
// level and mixer state, register shadow memory and the output register.
// Depends on psg_erw_pkg.
`timescale 1ns / 1ps

module psg_erw_dp #(
  parameter int SHADOW_DEPTH = psg_erw_pkg::SHADOW_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  psg_erw_pkg::ctrl_cmd_t cmd,
  output psg_erw_pkg::dp_sts_t   sts,
  input  logic [3:0]             in_operation,
  input  logic [2:0]             in_channel,
  input  logic [7:0]             in_data_value,
  input  logic [7:0]             in_reg_addr,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_write_valid,
  output logic [5:0]             out_write_addr,
  output logic [7:0]             out_write_data,
  output logic [7:0]             out_read_data,
  output logic                   out_status,
  output logic                   out_last
);
  import psg_erw_pkg::*;

  localparam int IDX_W = $clog2(SHADOW_DEPTH);

  // Latched input transaction.
  logic [3:0] op_r;
  logic [2:0] ch_r;
  logic [7:0] dv_r;
  logic [7:0] reg_r;

  // Channel level and mixer enable state.
  logic [5:0] level_r [NUM_CHANS];
  logic [7:0] mixer_r [2];

  // Register shadow with per-entry valid bits; unwritten entries read zero.
  logic [7:0]              shadow_mem [SHADOW_DEPTH];
  logic [SHADOW_DEPTH-1:0] shadow_vld_r;
  logic [7:0]              rd_data_r;
  logic                    rd_vld_r;

  // Output register.
  logic       out_valid_r;
  logic       out_wv_r;
  logic [5:0] out_addr_r;
  logic [7:0] out_data_r;
  logic [7:0] out_rd_r;
  logic       out_status_r;
  logic       out_last_r;

  // Result of the current step.
  logic       bad;
  logic       res_wv;
  logic [5:0] res_addr;
  logic [7:0] res_data;
  logic [7:0] res_rd;
  logic       res_last;
  logic       lv_we;
  logic [2:0] lv_idx;
  logic [5:0] lv_cur;
  logic [5:0] lv_new;
  logic       mx_we;
  logic       mx_idx;
  logic [7:0] mx_cur;
  logic [7:0] mx_new;
  logic [1:0] sub;
  logic [5:0] base;
  logic [1:0] mir_sub;
  logic [7:0] tone;
  logic [7:0] noise;
  init_wr_t   iw;

  // Item latch and shadow read at acceptance; no write can be in flight then.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_operation;
      ch_r      <= in_channel;
      dv_r      <= in_data_value;
      reg_r     <= in_reg_addr;
      rd_data_r <= shadow_mem[in_reg_addr[IDX_W-1:0]];
      rd_vld_r  <= (int'(in_reg_addr) < SHADOW_DEPTH) &&
                   shadow_vld_r[in_reg_addr[IDX_W-1:0]];
    end
  end

  // Field decode shared by the operations.
  assign sub     = ch_sub(ch_r);
  assign base    = ch_base(ch_r);
  assign mir_sub = reg_r[1:0];
  assign tone    = 8'h01 << sub;
  assign noise   = tone << 3;
  assign iw      = init_entry(cmd.step);

  assign bad = ((op_r >= OP_KEY_ON) && (op_r <= OP_PAN) && (ch_r >= 3'd6)) ||
               (op_r > OP_REG_WRITE) ||
               (((op_r == OP_REG_READ) || (op_r == OP_REG_WRITE)) && !reg_ok(reg_r));

  // One level entry and one mixer entry are touched per step.
  always_comb begin
    case (op_r)
      OP_INIT:      lv_idx = cmd.step[4:2];
      OP_REG_WRITE: lv_idx = reg_r[5] ? (3'd3 + {1'b0, mir_sub}) : {1'b0, mir_sub};
      default:      lv_idx = ch_r;
    endcase
    case (op_r)
      OP_INIT:      mx_idx = iw.addr[5];
      OP_REG_WRITE: mx_idx = reg_r[5];
      default:      mx_idx = (ch_r >= 3'd3);
    endcase
  end

  assign lv_cur = (lv_idx < 3'(NUM_CHANS)) ? level_r[lv_idx] : 6'h00;
  assign mx_cur = mixer_r[mx_idx];

  // Result and state update for the current step.
  always_comb begin
    res_wv   = 1'b0;
    res_addr = 6'h00;
    res_data = 8'h00;
    res_rd   = 8'h00;
    res_last = 1'b1;
    lv_we    = 1'b0;
    lv_new   = lv_cur;
    mx_we    = 1'b0;
    mx_new   = mx_cur;
    if (!bad) begin
      case (op_r)
        OP_INIT: begin
          res_wv   = 1'b1;
          res_addr = iw.addr;
          res_data = iw.data;
          res_last = (cmd.step == INIT_LAST);
          lv_we    = (cmd.step < INIT_SET_START) && (cmd.step[1:0] == 2'd2);
          lv_new   = 6'h00;
          mx_we    = (cmd.step >= INIT_SET_START) && (iw.addr[4:0] == REG_ENABLE[4:0]);
          mx_new   = MIX_INIT;
        end
        OP_KEY_ON, OP_KEY_OFF, OP_VOLUME: begin
          case (op_r)
            OP_KEY_ON:  lv_new = lv_cur | 6'h20;
            OP_KEY_OFF: lv_new = lv_cur & 6'h1F;
            default:    lv_new = {lv_cur[5:4], dv_r[6:3]};
          endcase
          lv_we    = 1'b1;
          res_wv   = 1'b1;
          res_addr = base | (REG_VOL + {4'b0000, sub});
          res_data = lv_new[5] ? {3'b000, lv_new[4:0]} : 8'h00;
        end
        OP_VOICE: begin
          res_wv   = 1'b1;
          res_last = (cmd.step == 6'd1);
          if (cmd.step == 6'd0) begin
            lv_new   = dv_r[4] ? {lv_cur[5], dv_r[4:0]} : {lv_cur[5], 1'b0, lv_cur[3:0]};
            lv_we    = 1'b1;
            res_addr = base | (REG_VOL + {4'b0000, sub});
            res_data = lv_new[5] ? {3'b000, lv_new[4:0]} : 8'h00;
          end else begin
            mx_new = mx_cur & ~tone;
            if (dv_r[5]) mx_new = mx_new | tone;
            mx_new = mx_new | noise;
            if (dv_r[6]) mx_new = mx_new & ~noise;
            mx_we    = 1'b1;
            res_addr = base | REG_ENABLE;
            res_data = mx_new;
          end
        end
        OP_ENV_SHAPE: begin
          res_wv   = 1'b1;
          res_addr = base | REG_SHAPE;
          res_data = dv_r;
        end
        OP_ENV_LO: begin
          res_wv   = 1'b1;
          res_addr = base | REG_ENV_LO;
          res_data = dv_r;
        end
        OP_ENV_HI: begin
          res_wv   = 1'b1;
          res_addr = base | REG_ENV_HI;
          res_data = dv_r;
        end
        OP_PAN: begin
          res_wv   = 1'b1;
          res_addr = base | (REG_PAN + {4'b0000, sub});
          res_data = dv_r;
        end
        OP_REG_READ: begin
          res_rd = rd_vld_r ? rd_data_r : 8'h00;
        end
        OP_REG_WRITE: begin
          res_wv   = 1'b1;
          res_addr = reg_r[5:0];
          res_data = dv_r;
          mx_we    = (reg_r[3:0] == REG_ENABLE[3:0]);
          mx_new   = dv_r;
          lv_we    = (reg_r[3:0] >= REG_VOL[3:0]) &&
                     (reg_r[3:0] < (REG_VOL[3:0] + 4'd3));
          lv_new   = {lv_cur[5], dv_r[4:0]};
        end
        default: begin
          res_wv = 1'b0;
        end
      endcase
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.last     = res_last;

  // Shadow memory write for each emitted register write inside the depth.
  always_ff @(posedge clk) begin
    if (cmd.emit && res_wv && (int'(res_addr) < SHADOW_DEPTH)) begin
      shadow_mem[res_addr[IDX_W-1:0]] <= res_data;
    end
  end

  // Valid bits, level and mixer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_vld_r <= '0;
      for (int i = 0; i < NUM_CHANS; i++) level_r[i] <= 6'h00;
      mixer_r[0] <= 8'h00;
      mixer_r[1] <= 8'h00;
    end else if (cmd.emit) begin
      if (res_wv && (int'(res_addr) < SHADOW_DEPTH)) begin
        shadow_vld_r[res_addr[IDX_W-1:0]] <= 1'b1;
      end
      if (lv_we) level_r[lv_idx] <= lv_new;
      if (mx_we) mixer_r[mx_idx] <= mx_new;
    end
  end

  // Output register: loaded by each result, emptied when the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_wv_r     <= res_wv;
      out_addr_r   <= res_addr;
      out_data_r   <= res_data;
      out_rd_r     <= res_rd;
      out_status_r <= bad;
      out_last_r   <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_valid = out_wv_r;
  assign out_write_addr  = out_addr_r;
  assign out_write_data  = out_data_r;
  assign out_read_data   = out_rd_r;
  assign out_status      = out_status_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (!out_wv_r && out_last_r && out_rd_r == 8'h00))
    else $error("rejected transaction carries a write or read data");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_wv_r) |-> (out_addr_r == 6'h00 && out_data_r == 8'h00))
    else $error("result without a write has nonzero address or data");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result did not reach the output register");
`endif

endmodule

### rtl/psg_event_register_writer.sv
// Top level of the tone chip register writer: controller plus datapath.
// Depends on psg_erw_pkg, psg_erw_if, psg_erw_ctrl and psg_erw_dp.
//
//   Channel     Direction  Handshake      Payload
//   in_item     sink       valid/ready    operation, channel, data_value, reg_addr
//   out_result  source     valid/ready    write_valid, write_addr, write_data,
//                                         read_data, status, last
//
// An item with one result is accepted, then its result is loaded into the output register.
// A voice item gives two results and init gives 34, one per cycle while not stalled.
// The output register sets the pace: a result waits there while out_result
// is stalled, and the next result of the same item waits behind it.
// A new item is accepted as soon as the previous item's last result is loaded.
// Reset (rst_n, synchronous) clears levels, mixer bytes and shadow valid bits.
`timescale 1ns / 1ps

module psg_event_register_writer #(
  parameter int SHADOW_DEPTH = psg_erw_pkg::SHADOW_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  psg_erw_in_if.sink   in_item,
  psg_erw_out_if.source out_result
);
  import psg_erw_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      ready;

  psg_erw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_item.ready = ready;

  psg_erw_dp #(
    .SHADOW_DEPTH (SHADOW_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_item.operation),
    .in_channel      (in_item.channel),
    .in_data_value   (in_item.data_value),
    .in_reg_addr     (in_item.reg_addr),
    .out_ready       (out_result.ready),
    .out_valid       (out_result.valid),
    .out_write_valid (out_result.write_valid),
    .out_write_addr  (out_result.write_addr),
    .out_write_data  (out_result.write_data),
    .out_read_data   (out_result.read_data),
    .out_status      (out_result.status),
    .out_last        (out_result.last)
  );

endmodule
